@@ rtl/programmable_fsm_engine_assert.svh @@
// Assertion macros for the programmable state machine engine.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef PROGRAMMABLE_FSM_ENGINE_ASSERT_SVH
`define PROGRAMMABLE_FSM_ENGINE_ASSERT_SVH

// Check an implication within the same clock edge, outside reset
`define PFSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check an implication at the following clock edge, outside reset
`define PFSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pfsm_pkg.sv @@
// Package for the programmable state machine engine.
// Holds request/result structs, command and status codes and default sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfsm_pkg;

    // Default table sizes
    localparam int NUM_STATES_DEF = 16;
    localparam int NUM_EVENTS_DEF = 16;

    // Width of every state and event field
    localparam int FIELD_W = 4;

    // Command codes
    localparam logic [1:0] MODE_DEFINE = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;
    localparam logic [1:0] MODE_FEED   = 2'd3;

    // Status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_UNDEF       = 2'd1;
    localparam logic [1:0] STATUS_STARTED     = 2'd2;
    localparam logic [1:0] STATUS_NOT_STARTED = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [FIELD_W-1:0] state_id;
        logic [FIELD_W-1:0] event_code;
        logic [FIELD_W-1:0] target_state;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               report_valid;
        logic [FIELD_W-1:0] previous_state;
        logic [FIELD_W-1:0] current_state;
        logic [FIELD_W-1:0] event_echo;
        logic               started;
    } t_out_rsp;

endpackage

`default_nettype wire

@@ rtl/pfsm_ram.sv @@
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfsm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read returns the old word on a collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/programmable_fsm_engine.sv @@
// Programmable table-driven state machine: command register, transition RAM, result register.
// Depends on pfsm_pkg, pfsm_ram and programmable_fsm_engine_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_req) takes one command request per
//   accepted cycle: define a state, add a transition, start, or feed an event.
//   Output channel (o_out_valid / i_out_ready / o_out_rsp) gives exactly one result per
//   request, in request order: status, step report and the present state.
//   A request accepted into the command register executes there, and its result is
//   written into the output register once the output register is free.
//   Throughput: one request per cycle, sustained while results are taken. The transition
//   RAM is read at the edge that accepts a request, addressed by the state that the
//   request ahead of it leaves, so a feed sees its target as the command register executes.
//   Stall: while the receiver holds i_out_ready low with a result waiting, the command
//   register holds its request and o_in_ready drops once both stages are full.
//   Reset (synchronous, active low) clears the defined-state mask, every transition valid
//   bit, the running flag and the present state; the RAM contents need no clearing, as an
//   entry is only used once its valid bit is set.
`timescale 1ns / 1ps
`default_nettype none
`include "programmable_fsm_engine_assert.svh"

module programmable_fsm_engine #(
    parameter int NUM_STATES = pfsm_pkg::NUM_STATES_DEF,
    parameter int NUM_EVENTS = pfsm_pkg::NUM_EVENTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pfsm_pkg::t_in_req  i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pfsm_pkg::t_out_rsp      o_out_rsp
);

    import pfsm_pkg::*;

    localparam int SW    = $clog2(NUM_STATES);
    localparam int EW    = $clog2(NUM_EVENTS);
    localparam int AW    = SW + EW;
    localparam int DEPTH = 2 ** AW;

    // Narrow a field to a state row index
    function automatic logic [SW-1:0] st_idx(input logic [FIELD_W-1:0] f);
        logic [SW+FIELD_W-1:0] w;
        w = {{SW{1'b0}}, f};
        return w[SW-1:0];
    endfunction

    // Narrow a field to an event column index
    function automatic logic [EW-1:0] ev_idx(input logic [FIELD_W-1:0] f);
        logic [EW+FIELD_W-1:0] w;
        w = {{EW{1'b0}}, f};
        return w[EW-1:0];
    endfunction

    function automatic logic st_in_range(input logic [FIELD_W-1:0] f);
        return {{(32-FIELD_W){1'b0}}, f} < 32'(NUM_STATES);
    endfunction

    function automatic logic ev_in_range(input logic [FIELD_W-1:0] f);
        return {{(32-FIELD_W){1'b0}}, f} < 32'(NUM_EVENTS);
    endfunction

    // Command register
    logic               r_s1_valid;
    t_in_req            r_s1_req;
    logic               r_byp_hit;
    logic [FIELD_W-1:0] r_byp_data;

    // Result register
    logic               r_out_valid;
    t_out_rsp           r_out_rsp;

    // Machine state
    logic [NUM_STATES-1:0] r_defined;
    logic [NUM_EVENTS-1:0] r_entry_valid [NUM_STATES];
    logic [FIELD_W-1:0]    r_present;
    logic                  r_running;

    // Handshake
    logic out_free;
    logic s1_adv;
    logic in_accept;

    // Execute stage
    logic               sid_ok;
    logic               tgt_ok;
    logic               ev_ok;
    logic               entry_hit;
    logic               present_defined;
    logic [FIELD_W-1:0] lookup_tgt;
    logic [FIELD_W-1:0] n_present;
    logic               n_running;
    logic               def_wr;
    logic               add_wr;
    t_out_rsp           rsp;

    // RAM ports
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [AW-1:0]      ram_rd_addr;
    logic [FIELD_W-1:0] ram_rd_data;
    logic [FIELD_W-1:0] rd_state;
    logic               n_byp_hit;

    // Advance the command register when the result register frees up
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    assign lookup_tgt = r_byp_hit ? r_byp_data : ram_rd_data;

    assign present_defined = st_in_range(r_present) && r_defined[st_idx(r_present)];

    // Execute the held request against the current machine state
    always_comb begin
        sid_ok    = st_in_range(r_s1_req.state_id) && r_defined[st_idx(r_s1_req.state_id)];
        tgt_ok    = st_in_range(r_s1_req.target_state)
                    && r_defined[st_idx(r_s1_req.target_state)];
        ev_ok     = ev_in_range(r_s1_req.event_code);
        entry_hit = st_in_range(r_present) && ev_ok
                    && r_entry_valid[st_idx(r_present)][ev_idx(r_s1_req.event_code)];

        n_present = r_present;
        n_running = r_running;
        def_wr    = 1'b0;
        add_wr    = 1'b0;

        rsp                = '0;
        rsp.status         = STATUS_OK;

        case (r_s1_req.mode)
            MODE_DEFINE: begin
                if (st_in_range(r_s1_req.state_id)) begin
                    def_wr = 1'b1;
                end else begin
                    rsp.status = STATUS_UNDEF;
                end
            end
            MODE_ADD: begin
                if (!sid_ok || !tgt_ok || !ev_ok) begin
                    rsp.status = STATUS_UNDEF;
                end else begin
                    add_wr = 1'b1;
                end
            end
            MODE_START: begin
                if (r_running) begin
                    rsp.status = STATUS_STARTED;
                end else if (!sid_ok) begin
                    rsp.status = STATUS_UNDEF;
                end else begin
                    n_running = 1'b1;
                    n_present = r_s1_req.state_id;
                end
            end
            MODE_FEED: begin
                if (!r_running) begin
                    rsp.status = STATUS_NOT_STARTED;
                end else begin
                    rsp.report_valid   = 1'b1;
                    rsp.previous_state = r_present;
                    rsp.event_echo     = r_s1_req.event_code;
                    if (entry_hit) begin
                        n_present = lookup_tgt;
                    end
                end
            end
            default: begin
                rsp.status = STATUS_OK;
            end
        endcase

        rsp.current_state = n_running ? n_present : '0;
        rsp.started       = n_running;
    end

    // Write the transition target; read the next request's entry at the accepting edge
    assign ram_wr_en   = s1_adv && add_wr;
    assign ram_wr_addr = {st_idx(r_s1_req.state_id), ev_idx(r_s1_req.event_code)};
    assign rd_state    = s1_adv ? n_present : r_present;
    assign ram_rd_addr = {st_idx(rd_state), ev_idx(i_in_req.event_code)};
    assign n_byp_hit   = ram_wr_en && (ram_wr_addr == ram_rd_addr);

    pfsm_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (DEPTH)
    ) u_target_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_s1_req.target_state),
        .i_rd_en   (in_accept),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Control state: stage valids, defined mask, valid bits, present state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_defined     <= '0;
            r_entry_valid <= '{default: '0};
            r_present     <= '0;
            r_running     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_present <= n_present;
                r_running <= n_running;
                if (def_wr) begin
                    r_defined[st_idx(r_s1_req.state_id)]     <= 1'b1;
                    r_entry_valid[st_idx(r_s1_req.state_id)] <= '0;
                end
                if (add_wr) begin
                    r_entry_valid[st_idx(r_s1_req.state_id)][ev_idx(r_s1_req.event_code)]
                        <= 1'b1;
                end
            end
        end
    end

    // Payload: hold the request and bypass data until the request advances
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req   <= i_in_req;
            r_byp_hit  <= n_byp_hit;
            r_byp_data <= r_s1_req.target_state;
        end
        if (s1_adv) begin
            r_out_rsp <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // Once started, the machine stays started
    `PFSM_ASSERT_NEXT(a_running_sticky, r_running, r_running, "running flag dropped")

    // A running machine always sits in a defined state
    `PFSM_ASSERT_NOW(a_present_defined, r_running, present_defined,
        "present state is not defined")

    // A step report only accompanies a good status on a started machine
    `PFSM_ASSERT_NOW(a_report_ok, o_out_valid && o_out_rsp.report_valid,
        o_out_rsp.status == STATUS_OK && o_out_rsp.started, "report with bad status")

    // A successful start leaves the machine running
    `PFSM_ASSERT_NEXT(a_start_runs,
        s1_adv && r_s1_req.mode == MODE_START && rsp.status == STATUS_OK, r_running,
        "start did not take effect")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for programmable_fsm_engine: directed command table, then random traffic.
// Depends on pfsm_pkg and the engine RTL; results are checked against an in-bench state machine.
`timescale 1ns / 1ps

module testbench;
    import pfsm_pkg::*;

    localparam int RANDOM_ITEMS  = 800;
    localparam int IDLE_PCT      = 22;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLDOFF_START = 400;
    localparam int HOLDOFF_LEN   = 64;
    localparam int DRAIN_CYCLES  = 4;
    localparam int QUIET_FIRST   = 300;
    localparam int QUIET_LAST    = 450;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_rsp o_out_rsp;

    programmable_fsm_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    // One row of the directed table; fixed rows carry their result typed in
    typedef struct {
        t_in_req  req;
        bit       fixed;
        t_out_rsp rsp;
    } t_cmd_row;

    t_cmd_row directed_rows[$];

    // Shadow copy of the engine's table and run state
    logic [15:0] shadow_defined;
    logic [15:0] shadow_row_valid [16];
    logic [3:0]  shadow_target [16][16];
    logic [3:0]  shadow_state;
    logic        shadow_running;

    t_out_rsp expected_results[$];
    int       mismatches = 0;
    bit       no_idle = 1'b0;

    // Clock: 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Execute one command on the shadow machine and return the result it should give
    function automatic t_out_rsp run_command(t_in_req req);
        t_out_rsp rsp;
        rsp = '0;
        rsp.status = STATUS_OK;
        case (req.mode)
            MODE_DEFINE: begin
                shadow_defined[req.state_id] = 1'b1;
                shadow_row_valid[req.state_id] = '0;
            end
            MODE_ADD: begin
                if (!shadow_defined[req.state_id] || !shadow_defined[req.target_state]) begin
                    rsp.status = STATUS_UNDEF;
                end else begin
                    shadow_row_valid[req.state_id][req.event_code] = 1'b1;
                    shadow_target[req.state_id][req.event_code] = req.target_state;
                end
            end
            MODE_START: begin
                if (shadow_running) begin
                    rsp.status = STATUS_STARTED;
                end else if (!shadow_defined[req.state_id]) begin
                    rsp.status = STATUS_UNDEF;
                end else begin
                    shadow_running = 1'b1;
                    shadow_state = req.state_id;
                end
            end
            default: begin
                if (!shadow_running) begin
                    rsp.status = STATUS_NOT_STARTED;
                end else begin
                    rsp.report_valid = 1'b1;
                    rsp.previous_state = shadow_state;
                    rsp.event_echo = req.event_code;
                    // Follow the stored transition, or stay put when there is none
                    if (shadow_row_valid[shadow_state][req.event_code])
                        shadow_state = shadow_target[shadow_state][req.event_code];
                end
            end
        endcase
        rsp.current_state = shadow_running ? shadow_state : 4'd0;
        rsp.started = shadow_running;
        return rsp;
    endfunction

    // Pick a defined state where one can be found quickly
    function automatic logic [3:0] pick_defined_state();
        logic [3:0] s;
        s = 4'($urandom_range(15));
        for (int k = 0; k < 16; k++) begin
            if (shadow_defined[s])
                return s;
            s = 4'($urandom_range(15));
        end
        return s;
    endfunction

    // Build a random command, biased towards adds between defined states and feeds that move
    function automatic t_in_req random_command();
        t_in_req    req;
        int         pick;
        logic [3:0] live_events [$];
        req.mode = 2'($urandom_range(3));
        req.state_id = 4'($urandom_range(15));
        req.event_code = 4'($urandom_range(15));
        req.target_state = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: leave every field random
        end else if (pick < 18) begin
            req.mode = MODE_DEFINE;
        end else if (pick < 48) begin
            req.mode = MODE_ADD;
            if ($urandom_range(99) < 85) begin
                req.state_id = pick_defined_state();
                req.target_state = pick_defined_state();
            end
        end else if (pick < 51) begin
            req.mode = MODE_START;
        end else begin
            req.mode = MODE_FEED;
            for (int e = 0; e < 16; e++) begin
                if (shadow_row_valid[shadow_state][e])
                    live_events.push_back(4'(e));
            end
            if (live_events.size() > 0 && $urandom_range(99) < 75)
                req.event_code = live_events[$urandom_range(live_events.size() - 1)];
        end
        return req;
    endfunction

    task automatic add_row(input logic [1:0] mode, input int sid, input int ev, input int tgt,
                           input bit fixed, input logic [1:0] status, input int cur,
                           input bit started);
        t_cmd_row row;
        row.req.mode = mode;
        row.req.state_id = 4'(sid);
        row.req.event_code = 4'(ev);
        row.req.target_state = 4'(tgt);
        row.fixed = fixed;
        row.rsp = '0;
        row.rsp.status = status;
        row.rsp.current_state = 4'(cur);
        row.rsp.started = started;
        directed_rows.push_back(row);
    endtask

    // Offer one request, hold it until accepted, then record its expected result
    task automatic send_request(input t_in_req req, input bit fixed, input t_out_rsp fixed_rsp);
        t_out_rsp predicted;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predicted = run_command(req);
        expected_results.push_back(fixed ? fixed_rsp : predicted);
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Stimulus: reset, directed table, random traffic, drain
    initial begin
        t_in_req req;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req <= '0;
        shadow_defined = '0;
        shadow_state = '0;
        shadow_running = 1'b0;
        for (int s = 0; s < 16; s++)
            shadow_row_valid[s] = '0;

        // Commands before start, undefined states, extremes
        add_row(MODE_FEED,   0,  0,  0, 1, STATUS_NOT_STARTED, 0, 0);
        add_row(MODE_FEED,  15, 15, 15, 1, STATUS_NOT_STARTED, 0, 0);
        add_row(MODE_START,  5,  0,  0, 1, STATUS_UNDEF,       0, 0);
        add_row(MODE_ADD,    0,  0,  0, 1, STATUS_UNDEF,       0, 0);
        add_row(MODE_DEFINE, 0,  0,  0, 1, STATUS_OK,          0, 0);
        add_row(MODE_DEFINE, 15, 0,  0, 1, STATUS_OK,          0, 0);
        add_row(MODE_ADD,    0, 15,  7, 1, STATUS_UNDEF,       0, 0);
        add_row(MODE_ADD,    3,  0,  0, 1, STATUS_UNDEF,       0, 0);
        add_row(MODE_DEFINE, 7,  0,  0, 1, STATUS_OK,          0, 0);
        add_row(MODE_ADD,    0, 15, 15, 1, STATUS_OK,          0, 0);
        add_row(MODE_ADD,   15,  0,  0, 1, STATUS_OK,          0, 0);
        // Overwrite an existing entry
        add_row(MODE_ADD,    0, 15,  7, 1, STATUS_OK,          0, 0);
        add_row(MODE_ADD,    7, 10, 15, 1, STATUS_OK,          0, 0);
        add_row(MODE_FEED,   0,  1,  0, 1, STATUS_NOT_STARTED, 0, 0);
        add_row(MODE_START, 15,  0,  0, 1, STATUS_OK,         15, 1);
        // Second start is refused
        add_row(MODE_START,  0,  0,  0, 1, STATUS_STARTED,    15, 1);
        add_row(MODE_FEED,   0,  0,  0, 0, STATUS_OK,          0, 0);
        add_row(MODE_FEED,   0,  3,  0, 0, STATUS_OK,          0, 0);
        add_row(MODE_FEED,   0, 15,  0, 0, STATUS_OK,          0, 0);
        add_row(MODE_FEED,   0, 10,  0, 0, STATUS_OK,          0, 0);
        // Redefine the present state: its transitions go, transitions into it stay
        add_row(MODE_DEFINE, 15, 0,  0, 0, STATUS_OK,          0, 0);
        add_row(MODE_FEED,   0,  0,  0, 0, STATUS_OK,          0, 0);
        add_row(MODE_ADD,   15,  5,  0, 0, STATUS_OK,          0, 0);
        add_row(MODE_FEED,   0,  5,  0, 0, STATUS_OK,          0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_request(directed_rows[r].req, directed_rows[r].fixed, directed_rows[r].rsp);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= QUIET_FIRST && n < QUIET_LAST);
            req = random_command();
            send_request(req, 1'b0, '0);
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        // Drain outstanding results, then allow for late strays
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off, quiet stretch alongside the sender
    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n)
                rx_cycle++;
            if (rx_cycle == HOLDOFF_START)
                hold_left = HOLDOFF_LEN;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: %p", o_out_rsp);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, o_out_rsp.status);
                check_field("report_valid", want.report_valid, o_out_rsp.report_valid);
                check_field("previous_state", want.previous_state, o_out_rsp.previous_state);
                check_field("current_state", want.current_state, o_out_rsp.current_state);
                check_field("event_echo", want.event_echo, o_out_rsp.event_echo);
                check_field("started", want.started, o_out_rsp.started);
            end
        end
    end

    // Watchdog: stop when neither channel moves for too long
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pfsm_pkg.sv
rtl/pfsm_ram.sv
rtl/programmable_fsm_engine.sv
tb/testbench.sv
